/* rtl/bole_pkg.sv */
`default_nettype none

package bole_pkg;

  // Number of entries the list can hold.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;

  // Request opcodes.
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_SHOW_FWD = 2'd2;
  localparam logic [1:0] OP_SHOW_BWD = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DELETED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_LISTED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LIST   = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

/* rtl/bounded_ordered_list_engine.sv */
`default_nettype none

// Bounded ordered list engine. The block keeps an ordered list of up to
// CAPACITY (16) signed 32-bit values in a small RAM, front at address 0.
// Each input beat carries an opcode and a value. An insert appends the value
// at the tail and returns one beat, or reports the list full. A delete scans
// from the front for the first equal entry, removes it and moves the later
// entries down one place, or reports that nothing matched. Show forward and
// show backward return one beat per entry in that order, with last set on
// the final one; an empty list gives a single empty beat. The block works on
// one request at a time and holds in_stall_o high until the request's final
// beat sits in the output register. All list traffic goes through the one
// RAM read port and one write port with a single equality comparator. A
// delete makes one read per entry up to the match, then one read and one
// write per entry behind it. No clearing pass is needed after reset; only
// written entries are ever read.
module bounded_ordered_list_engine
  import bole_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_beat_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic             dir_bwd_q, dir_bwd_d;
  logic [VAL_W-1:0] val_q, val_d;
  out_beat_t        res_q, res_d;

  logic             out_valid_q, out_valid_d;
  out_beat_t        out_beat_q, out_beat_d;
  logic             out_load;
  logic             out_free;

  logic             accept;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  // The single comparator: held search value against the word just read.
  logic             match;
  logic             more;
  logic             is_last;
  logic [IDX_W-1:0] bwd_addr;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  assign match    = (ram_rdata == val_q);
  assign more     = (ptr_q < count_q);
  assign is_last  = ({1'b0, rd_idx_q} == (count_q - CNT_W'(1)));
  assign bwd_addr = IDX_W'(count_q - CNT_W'(1) - ptr_q);

  bole_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    rd_idx_d   = rd_idx_q;
    rd_vld_d   = 1'b0;
    dir_bwd_d  = dir_bwd_q;
    val_d      = val_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[IDX_W-1:0];
    ram_wdata  = val_q;
    ram_re     = 1'b0;
    ram_raddr  = ptr_q[IDX_W-1:0];
    out_load   = 1'b0;
    out_beat_d = out_beat_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d             = in_beat_i.value;
          ptr_d             = '0;
          res_d.entry_value = in_beat_i.value;
          res_d.last        = 1'b1;
          dir_bwd_d         = (in_beat_i.opcode == OP_SHOW_BWD);
          unique case (in_beat_i.opcode)
            OP_INSERT: begin
              state_d = S_RESP;
              if (count_q == CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                // Append at the tail right away.
                ram_we       = 1'b1;
                ram_waddr    = count_q[IDX_W-1:0];
                ram_wdata    = in_beat_i.value;
                count_d      = count_q + CNT_W'(1);
                res_d.status = ST_INSERTED;
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                res_d.status = ST_NOTFOUND;
                state_d      = S_RESP;
              end else begin
                state_d = S_SEARCH;
              end
            end
            OP_SHOW_FWD, OP_SHOW_BWD: begin
              if (count_q == '0) begin
                res_d.status      = ST_EMPTY;
                res_d.entry_value = '0;
                state_d           = S_RESP;
              end else begin
                state_d = S_LIST;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // Reads stream one entry per cycle; each compare happens in the cycle after its read.
        if (rd_vld_q && match) begin
          ptr_d   = {1'b0, rd_idx_q} + CNT_W'(1);
          state_d = S_SHIFT;
        end else if (more) begin
          ram_re   = 1'b1;
          ram_raddr = ptr_q[IDX_W-1:0];
          rd_idx_d = ptr_q[IDX_W-1:0];
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_RESP;
        end
      end

      S_SHIFT: begin
        // Each word read at index j is written back at j - 1.
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[IDX_W-1:0];
          rd_idx_d  = ptr_q[IDX_W-1:0];
          rd_vld_d  = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          count_d      = count_q - CNT_W'(1);
          res_d.status = ST_DELETED;
          state_d      = S_RESP;
        end
      end

      S_LIST: begin
        // The RAM read register holds a word until the output takes it.
        if (rd_vld_q && out_free) begin
          out_load               = 1'b1;
          out_beat_d.status      = ST_LISTED;
          out_beat_d.entry_value = ram_rdata;
          out_beat_d.last        = is_last;
          if (is_last) begin
            state_d = S_IDLE;
          end
        end
        if (more && (!rd_vld_q || out_free)) begin
          ram_re    = 1'b1;
          ram_raddr = dir_bwd_q ? bwd_addr : ptr_q[IDX_W-1:0];
          rd_idx_d  = ptr_q[IDX_W-1:0];
          rd_vld_d  = 1'b1;
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          rd_vld_d = rd_vld_q && !out_free;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_beat_d = res_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    dir_bwd_q  <= dir_bwd_d;
    val_q      <= val_d;
    res_q      <= res_d;
    out_beat_q <= out_beat_d;
  end

endmodule

`default_nettype wire

/* rtl/bole_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
// The read data register only changes when a read is issued.
module bole_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_bounded_ordered_list_engine.sv */
`default_nettype none

module tb_bounded_ordered_list_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import bole_pkg::*;

  // Extremes of the signed value field.
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

  // The random part has this many requests. The last CALM_REQUESTS of them
  // run with neither side idling.
  localparam int RANDOM_REQUESTS = 74;
  localparam int CALM_REQUESTS   = 30;

  // This gives ample time for a stray beat to show up after the last expected
  // one.
  localparam int DRAIN_CYCLES = 4 * CAPACITY;

  // The scoreboard keeps its own copy of the list, works out the beats that
  // each accepted request must produce and checks the returned beats in order.
  class list_scoreboard;
    logic signed [VAL_W-1:0] entries [CAPACITY];
    int        count;
    out_beat_t expected_beats [$];
    int        mismatches;
    int        beats_checked;
    int        op_seen [4];
    int        full_rejects;
    int        misses;
    int        empty_shows;

    function new();
      count = 0;
      mismatches = 0;
      beats_checked = 0;
      full_rejects = 0;
      misses = 0;
      empty_shows = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void queue_beat(logic [2:0] status, logic signed [VAL_W-1:0] value,
                             logic is_last);
      out_beat_t b;
      b.status = status;
      b.entry_value = value;
      b.last = is_last;
      expected_beats.push_back(b);
    endfunction

    // Update the list for an accepted request and queue its result beats.
    function void note_request(in_beat_t req);
      int hit;
      int idx;
      op_seen[req.opcode]++;
      case (req.opcode)
        OP_INSERT: begin
          if (count >= CAPACITY) begin
            full_rejects++;
            queue_beat(ST_FULL, req.value, 1'b1);
          end else begin
            entries[count] = req.value;
            count++;
            queue_beat(ST_INSERTED, req.value, 1'b1);
          end
        end
        OP_DELETE: begin
          hit = count;
          for (int i = 0; i < count; i++) begin
            if (entries[i] == req.value) begin
              hit = i;
              break;
            end
          end
          if (hit == count) begin
            misses++;
            queue_beat(ST_NOTFOUND, req.value, 1'b1);
          end else begin
            for (int i = hit; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
            queue_beat(ST_DELETED, req.value, 1'b1);
          end
        end
        default: begin
          if (count == 0) begin
            empty_shows++;
            queue_beat(ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < count; i++) begin
              idx = (req.opcode == OP_SHOW_FWD) ? i : count - 1 - i;
              queue_beat(ST_LISTED, entries[idx], i + 1 == count);
            end
          end
        end
      endcase
    endfunction

    function void report(string what, out_beat_t want, out_beat_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected status %0d value %0d last %0b,", $time, what,
                 want.status, want.entry_value, want.last,
                 " got status %0d value %0d last %0b",
                 got.status, got.entry_value, got.last);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report("beat with nothing pending", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.status !== want.status || got.entry_value !== want.entry_value ||
            got.last !== want.last)
          report("wrong beat", want, got);
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_beat_t  in_beat_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_beat_o;

  // While idle_on is set, the sender leaves gaps and the receiver stalls, both
  // in random bursts.
  bit idle_on = 1'b1;
  int stall_left = 0;

  list_scoreboard list_sb = new();

  bounded_ordered_list_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure. A burst is started at random, then held for the
  // number of cycles drawn; each edge makes exactly one assignment to the stall.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // All testbench drives are nonblocking, so the values seen here at the edge
  // are the ones the block sampled. A beat counts when valid is high and the
  // stall is low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) list_sb.check_beat(out_beat_o);
  end

  // Present one request and hold it until the block takes it. Valid is left
  // high on return, so a following request goes out back to back with a
  // single assignment; a gap lowers it first.
  task automatic send_request(input logic [1:0] op, input logic signed [VAL_W-1:0] value);
    in_beat_t req;
    req.opcode = op;
    req.value = value;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    list_sb.note_request(req);
  endtask

  // Random values lean toward a few small numbers, so that deletes and
  // duplicates hit often, with the extremes and full-range values mixed in.
  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 4))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [VAL_W-1:0] fill_vals [CAPACITY];
    logic signed [VAL_W-1:0] value;
    logic [1:0] op;
    int insert_pct;
    int pick;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Showing and deleting on an empty list come first.
    send_request(OP_SHOW_FWD, '1);
    send_request(OP_SHOW_BWD, '0);
    send_request(OP_DELETE, 32'sd5);

    // Fill the list to capacity with the value extremes, alternating bit
    // patterns and a duplicate pair, then push one more to see it rejected.
    fill_vals[0] = VAL_MIN;
    fill_vals[1] = VAL_MAX;
    fill_vals[2] = '0;
    fill_vals[3] = '1;
    fill_vals[4] = 32'sd7;
    fill_vals[5] = 32'sd7;
    fill_vals[6] = 32'sh5555_5555;
    fill_vals[7] = 32'shAAAA_AAAA;
    for (int i = 8; i < CAPACITY; i++) fill_vals[i] = 100 + 3 * i;
    for (int i = 0; i < CAPACITY; i++) send_request(OP_INSERT, fill_vals[i]);
    send_request(OP_INSERT, 32'sd42);

    // A full list in both directions gives the longest runs of beats.
    send_request(OP_SHOW_FWD, 32'sh0F0F_0F0F);
    send_request(OP_SHOW_BWD, 32'shF0F0_F0F0);

    // Delete at the front, at the tail, the first of two equal entries in
    // the middle, and a value that is not in the list.
    send_request(OP_DELETE, VAL_MIN);
    send_request(OP_DELETE, fill_vals[CAPACITY-1]);
    send_request(OP_DELETE, 32'sd7);
    send_request(OP_DELETE, 32'sd999_999);

    // Random part. Every twenty requests the insert share is drawn anew, so the
    // list drifts between filling up and draining toward empty.
    insert_pct = 55;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 20 == 0) insert_pct = ($urandom_range(0, 1) != 0) ? 55 : 20;
      if (n >= RANDOM_REQUESTS - CALM_REQUESTS) idle_on = 1'b0;
      else if (n % 15 == 0) idle_on = ($urandom_range(0, 3) != 0);

      pick = $urandom_range(0, 99);
      if (pick < insert_pct) op = OP_INSERT;
      else if (pick < insert_pct + 30) op = OP_DELETE;
      else if (pick < insert_pct + 30 + (70 - insert_pct) / 2) op = OP_SHOW_FWD;
      else op = OP_SHOW_BWD;

      // Most deletes name a value that is present, at a random position.
      if (op == OP_DELETE && list_sb.count > 0 && $urandom_range(0, 9) < 7)
        value = list_sb.entries[$urandom_range(0, list_sb.count - 1)];
      else
        value = random_value();

      send_request(op, value);
    end
    in_valid_i <= 1'b0;

    // Wait for every pending beat, then give a stray beat time to appear.
    while (list_sb.expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d inserts, %0d deletes and %0d shows; %0d result beats checked.",
             list_sb.op_seen[OP_INSERT], list_sb.op_seen[OP_DELETE],
             list_sb.op_seen[OP_SHOW_FWD] + list_sb.op_seen[OP_SHOW_BWD],
             list_sb.beats_checked);
    $display("Saw %0d full rejects, %0d missed deletes, %0d empty shows, %0d mismatches.",
             list_sb.full_rejects, list_sb.misses, list_sb.empty_shows,
             list_sb.mismatches);
    if (list_sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog. A correct run, even with every show at full length and every
  // beat stalled for the longest burst, ends far sooner than this.
  initial begin
    #2_000_000;
    $display("Timed out with %0d beats still pending.", list_sb.expected_beats.size());
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/bole_pkg.sv
rtl/bole_ram.sv
rtl/bounded_ordered_list_engine.sv
tb/sv/tb_bounded_ordered_list_engine.sv
